FILE: rtl/tksc_pkg.sv
// Shared constants, types and controller/datapath interface structs for the top-k score block.
package tksc_pkg;

    localparam int HEAP_DEPTH = 1024;
    localparam int ADDR_W     = $clog2(HEAP_DEPTH);
    localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
    localparam int LINK_W     = ADDR_W + 2;

    localparam int SAMPLE_W   = 32;
    localparam int VAL_W      = 31;
    localparam int KEEP_W     = 11;
    localparam int COST_W     = 31;
    localparam int IDX_W      = 32;
    localparam int SUM_W      = VAL_W + ADDR_W;
    localparam int PROD_W     = COST_W + IDX_W;
    localparam int SCORE_W    = 64;
    localparam int BEST_W     = 63;

    localparam int PDATA_W    = 32;
    localparam int PADDR_W    = 3;

    localparam logic REG_KEEP_COUNT = 1'b0;
    localparam logic REG_COST       = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_BEST,
        ST_UP_START,
        ST_UP_STEP,
        ST_UP_FIN,
        ST_DN_START,
        ST_DN_STEP,
        ST_DN_FIN,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic mul;
        logic sum;
        logic best;
        logic up_start;
        logic up_step;
        logic up_fin;
        logic dn_start;
        logic dn_step;
        logic dn_fin;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic positive;
        logic full;
        logic replace;
        logic pos_zero;
        logic up_move;
        logic parent_zero;
        logic dn_leaf;
        logic dn_move;
        logic dn_more;
        logic out_free;
    } t_stat;

endpackage

FILE: rtl/top_k_running_sum_score.sv
// Top level: configuration registers, controller and datapath of the top-k running-sum scorer.
//
// Input channel (i_in_valid / o_in_ready) takes one beat per item: a signed
// sample and a start flag that clears heap, sum, index and best score first.
// Output channel (o_out_valid / i_out_ready) returns one beat per item with
// the running best score, clamped at zero.
// One item is in work at a time. A sample of zero or less goes from the
// multiply step straight to the output step. A positive sample also passes
// the sum and best steps and ends there when the heap is full and the root
// stays; otherwise it walks the heap up on insert or down on replace, one
// level per step and at most 10 levels. The next beat is taken back in
// idle, once the output step has handed its result to the output register.
// The heap memory has one write and two read ports; the walk visits one
// level per cycle and sets the rate.
// The output register frees the controller: the next item is taken while a
// result still waits, and the controller only holds in its output step if
// the previous result is still not taken.
// Reset (synchronous, active low) empties the block and sets keep_count to 1
// and cost_per_item to 0. Registers are to be written over the APB port only while idle; the block does not enforce it.
module top_k_running_sum_score (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [tksc_pkg::SAMPLE_W-1:0] i_sample_value,
    input  logic                                 i_start_sequence,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic        [tksc_pkg::BEST_W-1:0]   o_best_score,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic        [tksc_pkg::PADDR_W-1:0]  paddr,
    input  logic        [tksc_pkg::PDATA_W-1:0]  pwdata,
    output logic        [tksc_pkg::PDATA_W-1:0]  prdata,
    output logic                                 pready
);

    logic [tksc_pkg::KEEP_W-1:0] r_keep_count;
    logic [tksc_pkg::COST_W-1:0] r_cost_per_item;
    logic                        reg_sel;
    logic                        wr_en;

    tksc_pkg::t_cmd  cmd;
    tksc_pkg::t_stat stat;

    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep_count    <= tksc_pkg::KEEP_W'(1);
            r_cost_per_item <= '0;
        end else if (wr_en) begin
            case (reg_sel)
                tksc_pkg::REG_KEEP_COUNT: r_keep_count    <= pwdata[tksc_pkg::KEEP_W-1:0];
                tksc_pkg::REG_COST:       r_cost_per_item <= pwdata[tksc_pkg::COST_W-1:0];
                default: begin
                    r_keep_count <= r_keep_count;
                end
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            tksc_pkg::REG_KEEP_COUNT: prdata = tksc_pkg::PDATA_W'(r_keep_count);
            tksc_pkg::REG_COST:       prdata = tksc_pkg::PDATA_W'(r_cost_per_item);
            default:                  prdata = '0;
        endcase
    end

    tksc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    tksc_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_sample_value   (i_sample_value),
        .i_start_sequence (i_start_sequence),
        .i_keep_count     (r_keep_count),
        .i_cost_per_item  (r_cost_per_item),
        .i_out_ready      (i_out_ready),
        .o_out_valid      (o_out_valid),
        .o_best_score     (o_best_score)
    );

endmodule

FILE: rtl/tksc_ctrl.sv
// Sequencing state machine: item load, score update and heap sift steps.
module tksc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  tksc_pkg::t_stat  i_stat,
    output tksc_pkg::t_cmd   o_cmd
);

    tksc_pkg::t_state r_state;
    tksc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tksc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            tksc_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = tksc_pkg::ST_MUL;
            end
            tksc_pkg::ST_MUL: begin
                n_state = i_stat.positive ? tksc_pkg::ST_SUM : tksc_pkg::ST_OUT;
            end
            tksc_pkg::ST_SUM: begin
                n_state = tksc_pkg::ST_BEST;
            end
            tksc_pkg::ST_BEST: begin
                if (!i_stat.full) n_state = tksc_pkg::ST_UP_START;
                else if (i_stat.replace) n_state = tksc_pkg::ST_DN_START;
                else n_state = tksc_pkg::ST_OUT;
            end
            tksc_pkg::ST_UP_START: begin
                n_state = i_stat.pos_zero ? tksc_pkg::ST_OUT : tksc_pkg::ST_UP_STEP;
            end
            tksc_pkg::ST_UP_STEP: begin
                if (!i_stat.up_move) n_state = tksc_pkg::ST_OUT;
                else if (i_stat.parent_zero) n_state = tksc_pkg::ST_UP_FIN;
            end
            tksc_pkg::ST_UP_FIN: begin
                n_state = tksc_pkg::ST_OUT;
            end
            tksc_pkg::ST_DN_START: begin
                n_state = i_stat.dn_leaf ? tksc_pkg::ST_OUT : tksc_pkg::ST_DN_STEP;
            end
            tksc_pkg::ST_DN_STEP: begin
                if (!i_stat.dn_move) n_state = tksc_pkg::ST_OUT;
                else if (!i_stat.dn_more) n_state = tksc_pkg::ST_DN_FIN;
            end
            tksc_pkg::ST_DN_FIN: begin
                n_state = tksc_pkg::ST_OUT;
            end
            tksc_pkg::ST_OUT: begin
                if (i_stat.out_free) n_state = tksc_pkg::ST_IDLE;
            end
            default: begin
                n_state = tksc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            tksc_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            tksc_pkg::ST_MUL:      o_cmd.mul      = 1'b1;
            tksc_pkg::ST_SUM:      o_cmd.sum      = 1'b1;
            tksc_pkg::ST_BEST:     o_cmd.best     = 1'b1;
            tksc_pkg::ST_UP_START: o_cmd.up_start = 1'b1;
            tksc_pkg::ST_UP_STEP:  o_cmd.up_step  = 1'b1;
            tksc_pkg::ST_UP_FIN:   o_cmd.up_fin   = 1'b1;
            tksc_pkg::ST_DN_START: o_cmd.dn_start = 1'b1;
            tksc_pkg::ST_DN_STEP:  o_cmd.dn_step  = 1'b1;
            tksc_pkg::ST_DN_FIN:   o_cmd.dn_fin   = 1'b1;
            tksc_pkg::ST_OUT:      o_cmd.out_load = i_stat.out_free;
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

FILE: rtl/tksc_dp.sv
// Datapath: heap memory, sum/index/best registers, cost multiplier and output register.
module tksc_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  tksc_pkg::t_cmd                       i_cmd,
    output tksc_pkg::t_stat                      o_stat,
    input  logic signed [tksc_pkg::SAMPLE_W-1:0] i_sample_value,
    input  logic                                 i_start_sequence,
    input  logic        [tksc_pkg::KEEP_W-1:0]   i_keep_count,
    input  logic        [tksc_pkg::COST_W-1:0]   i_cost_per_item,
    input  logic                                 i_out_ready,
    output logic                                 o_out_valid,
    output logic        [tksc_pkg::BEST_W-1:0]   o_best_score
);

    logic [tksc_pkg::VAL_W-1:0]  r_heap [tksc_pkg::HEAP_DEPTH];

    logic [tksc_pkg::SAMPLE_W-1:0]      r_sample;
    logic [tksc_pkg::CNT_W-1:0]         r_size;
    logic [tksc_pkg::SUM_W-1:0]         r_sum;
    logic [tksc_pkg::IDX_W-1:0]         r_idx;
    logic signed [tksc_pkg::SCORE_W-1:0] r_best;
    logic [tksc_pkg::PROD_W-1:0]        r_cost;
    logic [tksc_pkg::SUM_W-1:0]         r_part;
    logic                               r_replace;
    logic [tksc_pkg::ADDR_W-1:0]        r_pos;
    logic [tksc_pkg::VAL_W-1:0]         r_rd_a;
    logic [tksc_pkg::VAL_W-1:0]         r_rd_b;
    logic                               r_out_valid;
    logic [tksc_pkg::BEST_W-1:0]        r_out_best;

    logic [tksc_pkg::VAL_W-1:0]   val;
    logic                         positive;
    logic [tksc_pkg::CNT_W-1:0]   k_eff;
    logic                         full;
    logic [tksc_pkg::IDX_W-1:0]   idx_base;
    logic [tksc_pkg::IDX_W-1:0]   idx_next;
    logic [tksc_pkg::PROD_W-1:0]  prod;
    logic [tksc_pkg::SUM_W:0]     part_calc;
    logic [tksc_pkg::VAL_W-1:0]   root_term;
    logic signed [tksc_pkg::SCORE_W-1:0] cand;

    logic [tksc_pkg::ADDR_W-1:0]  parent_addr;
    logic [tksc_pkg::ADDR_W-1:0]  grand_addr;
    logic [tksc_pkg::LINK_W-1:0]  size_ext;
    logic [tksc_pkg::LINK_W-1:0]  left;
    logic [tksc_pkg::LINK_W-1:0]  right;
    logic                         right_ok;
    logic                         pick_right;
    logic [tksc_pkg::VAL_W-1:0]   pick_val;
    logic [tksc_pkg::ADDR_W-1:0]  pick_addr;
    logic [tksc_pkg::LINK_W-1:0]  next_left;
    logic [tksc_pkg::LINK_W-1:0]  next_right;
    logic                         up_move;
    logic                         dn_move;
    logic                         dn_leaf;
    logic                         size_inc;

    logic                         we;
    logic [tksc_pkg::ADDR_W-1:0]  wa;
    logic [tksc_pkg::VAL_W-1:0]   wd;
    logic [tksc_pkg::ADDR_W-1:0]  rd_addr_a;
    logic [tksc_pkg::ADDR_W-1:0]  rd_addr_b;

    assign val      = r_sample[tksc_pkg::VAL_W-1:0];
    assign positive = !r_sample[tksc_pkg::SAMPLE_W-1] && (r_sample != '0);

    // Clamp keep_count into 1..HEAP_DEPTH
    always_comb begin
        if (i_keep_count == '0) begin
            k_eff = tksc_pkg::CNT_W'(1);
        end else if (32'(i_keep_count) > 32'(tksc_pkg::HEAP_DEPTH)) begin
            k_eff = tksc_pkg::CNT_W'(tksc_pkg::HEAP_DEPTH);
        end else begin
            k_eff = tksc_pkg::CNT_W'(i_keep_count);
        end
    end
    assign full = (r_size >= k_eff);

    // Start clears the index before the saturating advance
    assign idx_base = i_start_sequence ? '0 : r_idx;
    assign idx_next = (&idx_base) ? idx_base : idx_base + 1'b1;

    assign prod = {{tksc_pkg::IDX_W{1'b0}}, i_cost_per_item}
                * {{tksc_pkg::COST_W{1'b0}}, r_idx};

    // Root arrives from the read issued in the multiply cycle
    assign root_term = full ? r_rd_a : '0;
    assign part_calc = {1'b0, r_sum} + (tksc_pkg::SUM_W+1)'(val)
                     - (tksc_pkg::SUM_W+1)'(root_term);
    assign cand = signed'(tksc_pkg::SCORE_W'(r_part)) - signed'(tksc_pkg::SCORE_W'(r_cost));

    // Heap links
    assign parent_addr = (r_pos - 1'b1) >> 1;
    assign grand_addr  = (parent_addr - 1'b1) >> 1;
    assign size_ext    = tksc_pkg::LINK_W'(r_size);
    assign left        = (tksc_pkg::LINK_W'(r_pos) << 1) + 1'b1;
    assign right       = left + 1'b1;
    assign right_ok    = (right < size_ext);
    assign pick_right  = right_ok && (r_rd_b < r_rd_a);
    assign pick_val    = pick_right ? r_rd_b : r_rd_a;
    assign pick_addr   = pick_right ? right[tksc_pkg::ADDR_W-1:0] : left[tksc_pkg::ADDR_W-1:0];
    assign next_left   = (tksc_pkg::LINK_W'(pick_addr) << 1) + 1'b1;
    assign next_right  = next_left + 1'b1;
    assign up_move     = (val < r_rd_a);
    assign dn_move     = (pick_val < val);
    assign dn_leaf     = (left >= size_ext);

    always_comb begin
        we        = 1'b0;
        wa        = r_pos;
        wd        = val;
        rd_addr_a = '0;
        rd_addr_b = '0;
        size_inc  = 1'b0;
        if (i_cmd.up_start) begin
            if (r_pos == '0) begin
                we       = 1'b1;
                size_inc = 1'b1;
            end else begin
                rd_addr_a = parent_addr;
            end
        end
        if (i_cmd.up_step) begin
            we = 1'b1;
            if (up_move) begin
                // pull the parent down, look at the next ancestor
                wd        = r_rd_a;
                rd_addr_a = grand_addr;
            end else begin
                size_inc = 1'b1;
            end
        end
        if (i_cmd.up_fin) begin
            we       = 1'b1;
            size_inc = 1'b1;
        end
        if (i_cmd.dn_start) begin
            if (dn_leaf) begin
                we = 1'b1;
            end else begin
                rd_addr_a = left[tksc_pkg::ADDR_W-1:0];
                rd_addr_b = right[tksc_pkg::ADDR_W-1:0];
            end
        end
        if (i_cmd.dn_step) begin
            we = 1'b1;
            if (dn_move) begin
                // lift the smaller child, fetch its children
                wd        = pick_val;
                rd_addr_a = next_left[tksc_pkg::ADDR_W-1:0];
                rd_addr_b = next_right[tksc_pkg::ADDR_W-1:0];
            end
        end
        if (i_cmd.dn_fin) begin
            we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_heap[wa] <= wd;
        end
        r_rd_a <= r_heap[rd_addr_a];
        r_rd_b <= r_heap[rd_addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size      <= '0;
            r_sum       <= '0;
            r_idx       <= '0;
            r_best      <= '0;
            r_replace   <= 1'b0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_idx <= idx_next;
                if (i_start_sequence) begin
                    r_size <= '0;
                    r_sum  <= '0;
                    r_best <= '0;
                end
            end
            if (i_cmd.sum) begin
                r_replace <= full && (val > r_rd_a);
            end
            if (i_cmd.best) begin
                if (cand > r_best) r_best <= cand;
                if (!full || r_replace) r_sum <= r_part;
                r_pos <= full ? '0 : r_size[tksc_pkg::ADDR_W-1:0];
            end
            if (i_cmd.up_step && up_move) begin
                r_pos <= parent_addr;
            end
            if (i_cmd.dn_step && dn_move) begin
                r_pos <= pick_addr;
            end
            if (size_inc) begin
                r_size <= r_size + 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sample <= i_sample_value;
        end
        if (i_cmd.mul) begin
            r_cost <= prod;
        end
        if (i_cmd.sum) begin
            r_part <= part_calc[tksc_pkg::SUM_W-1:0];
        end
        if (i_cmd.out_load) begin
            r_out_best <= r_best[tksc_pkg::BEST_W-1:0];
        end
    end

    always_comb begin
        o_stat             = '0;
        o_stat.positive    = positive;
        o_stat.full        = full;
        o_stat.replace     = r_replace;
        o_stat.pos_zero    = (r_pos == '0);
        o_stat.up_move     = up_move;
        o_stat.parent_zero = (parent_addr == '0);
        o_stat.dn_leaf     = dn_leaf;
        o_stat.dn_move     = dn_move;
        o_stat.dn_more     = (next_left < size_ext);
        o_stat.out_free    = !r_out_valid || i_out_ready;
    end

    assign o_out_valid  = r_out_valid;
    assign o_best_score = r_out_best;

endmodule

FILE: rtl/tksc_checker.sv
// Port-level checker for the top-k running-sum scorer, bound to the top level.
module tksc_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               o_in_ready,
    input  logic                               o_out_valid,
    input  logic                               i_out_ready,
    input  logic [tksc_pkg::BEST_W-1:0]        o_best_score
);

    // Come out of reset empty and ready
    a_reset_clean: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> (!o_out_valid && o_in_ready))
        else $error("block not idle after reset");

    // One item in work at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken again right after a beat");

    // A result appears only after the item left the input side
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("result appeared while idle");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_best_score)))
        else $error("stalled output beat changed");

endmodule

bind top_k_running_sum_score tksc_checker u_tksc_checker (.*);
